/* hdl/limit_order_matching_core_macros.svh */
// Assertion macros used by the checker file.
`ifndef LIMIT_ORDER_MATCHING_CORE_MACROS_SVH
`define LIMIT_ORDER_MATCHING_CORE_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define LOM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define LOM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/lom_pkg.sv */
// ----------------------------------------------------------------------------
// lom_pkg
// Types and constants for the limit order matching core.
// ----------------------------------------------------------------------------
package lom_pkg;
    localparam int BOOK_DEPTH_DEF = 16;

    localparam logic [1:0] KIND_TRADE   = 2'd0;
    localparam logic [1:0] KIND_RESTED  = 2'd1;
    localparam logic [1:0] KIND_DROPPED = 2'd2;

    typedef struct packed {
        logic        is_sell;
        logic [15:0] order_id;
        logic [15:0] limit_price;
        logic [15:0] order_qty;
    } order_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] aggressor_id;
        logic [15:0] resting_id;
        logic [15:0] fill_price;
        logic [15:0] fill_qty;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] price;
        logic [15:0] qty;
    } slot_t;

    // Per-cycle command broadcast to every cell of one side.
    typedef struct packed {
        logic        shift_up;   // remove head: take entry from right neighbor
        logic        dec_head;   // reduce head quantity by dec_qty
        logic [15:0] dec_qty;
        logic        insert;     // insert new entry at price position
        slot_t       ins;
        logic        ins_sell;   // side ordering of this table
    } cell_cmd_t;
endpackage

/* hdl/lom_cell.sv */
// ----------------------------------------------------------------------------
// lom_cell
// One book entry: holds a slot and moves it with its neighbors.
// ----------------------------------------------------------------------------
module lom_cell
    import lom_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      is_head,
    input  cell_cmd_t cmd,
    input  slot_t     left_slot,
    input  logic      left_valid,
    input  logic      left_worse,
    input  slot_t     right_slot,
    input  logic      right_valid,
    output slot_t     slot,
    output logic      valid,
    output logic      worse
);
    slot_t slot_reg, slot_next;
    logic  valid_reg, valid_next;

    // Strictly worse than the incoming price on this side.
    assign worse = valid_reg &&
        (cmd.ins_sell ? (slot_reg.price > cmd.ins.price) : (slot_reg.price < cmd.ins.price));

    always_comb begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        if (cmd.shift_up) begin
            slot_next  = right_slot;
            valid_next = right_valid;
        end else if (cmd.dec_head && is_head) begin
            slot_next.qty = slot_reg.qty - cmd.dec_qty;
        end else if (cmd.insert) begin
            // Entries at or after the insert point move one place down.
            if (worse || !valid_reg) begin
                // The insert point is the first such cell: head, or left stays put.
                if (is_head || (left_valid && !left_worse)) begin
                    slot_next  = cmd.ins;
                    valid_next = 1'b1;
                end else begin
                    slot_next  = left_slot;
                    valid_next = left_valid;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        slot_reg <= slot_next;
    end

    assign slot  = slot_reg;
    assign valid = valid_reg;
endmodule

/* hdl/lom_side.sv */
// ----------------------------------------------------------------------------
// lom_side
// One side of the book: a chain of cells, head first.
// ----------------------------------------------------------------------------
module lom_side
    import lom_pkg::*;
#(
    parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cmd_t cmd,
    output slot_t     head_slot,
    output logic      head_valid,
    output logic      full
);
    slot_t slots  [BOOK_DEPTH];
    logic  valids [BOOK_DEPTH];
    logic  worses [BOOK_DEPTH];

    for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
        slot_t ls, rs;
        logic  lv, lw, rv;
        if (g == 0) begin : g_first
            assign ls = '0;
            assign lv = 1'b0;
            assign lw = 1'b0;
        end else begin : g_mid
            assign ls = slots[g-1];
            assign lv = valids[g-1];
            assign lw = worses[g-1];
        end
        if (g == BOOK_DEPTH - 1) begin : g_last
            assign rs = '0;
            assign rv = 1'b0;
        end else begin : g_next
            assign rs = slots[g+1];
            assign rv = valids[g+1];
        end
        lom_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .is_head    (g == 0),
            .cmd        (cmd),
            .left_slot  (ls),
            .left_valid (lv),
            .left_worse (lw),
            .right_slot (rs),
            .right_valid(rv),
            .slot       (slots[g]),
            .valid      (valids[g]),
            .worse      (worses[g])
        );
    end

    assign head_slot  = slots[0];
    assign head_valid = valids[0];
    assign full       = valids[BOOK_DEPTH-1];
endmodule

/* hdl/limit_order_matching_core.sv */
// ----------------------------------------------------------------------------
// limit_order_matching_core
// Price-time priority matching of limit orders against a two-sided book.
// ----------------------------------------------------------------------------
//  channel | dir | payload  | handshake
//  s_      | in  | order_t  | s_valid / s_ready
//  m_      | out | result_t | m_valid / m_ready
//
// An order is accepted, then yields one result per fill (at most BOOK_DEPTH)
// and one for any remainder, which rests or is dropped; the walk of the
// opposite chain's head goes one entry per cycle while the output is not
// stalled.
// A zero-quantity order is dropped on acceptance with no result.
// Reset empties both books at once (valid bit per cell).
// A stalled output holds the walk; the next order is taken once the last
// result of the current one is in the output register and that register is free or being taken.
module limit_order_matching_core
    import lom_pkg::*;
#(
    parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  order_t  s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    logic    state_reg, state_next;
    order_t  ord_reg, ord_next;
    logic    m_valid_reg, m_valid_next;
    result_t m_data_reg, m_data_next;

    cell_cmd_t bid_cmd, ask_cmd;
    slot_t     bid_head, ask_head, opp_head;
    logic      bid_hv, ask_hv, bid_full, ask_full, opp_hv, own_full;
    logic      out_free, crosses;
    logic [15:0] fill;

    lom_side #(.BOOK_DEPTH(BOOK_DEPTH)) u_bid (
        .aclk(aclk), .aresetn(aresetn), .cmd(bid_cmd),
        .head_slot(bid_head), .head_valid(bid_hv), .full(bid_full)
    );
    lom_side #(.BOOK_DEPTH(BOOK_DEPTH)) u_ask (
        .aclk(aclk), .aresetn(aresetn), .cmd(ask_cmd),
        .head_slot(ask_head), .head_valid(ask_hv), .full(ask_full)
    );

    // Output register frees when empty or being taken.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;

    assign opp_head = ord_reg.is_sell ? bid_head : ask_head;
    assign opp_hv   = ord_reg.is_sell ? bid_hv : ask_hv;
    assign own_full = ord_reg.is_sell ? ask_full : bid_full;
    assign crosses  = opp_hv && (ord_reg.is_sell ? (opp_head.price >= ord_reg.limit_price)
                                                 : (opp_head.price <= ord_reg.limit_price));
    assign fill     = (opp_head.qty < ord_reg.order_qty) ? opp_head.qty : ord_reg.order_qty;

    always_comb begin
        cell_cmd_t opp_cmd, own_cmd;
        opp_cmd          = '0;
        own_cmd          = '0;
        own_cmd.ins_sell = ord_reg.is_sell;
        own_cmd.ins      = '{id: ord_reg.order_id, price: ord_reg.limit_price,
                             qty: ord_reg.order_qty};
        opp_cmd.ins_sell = !ord_reg.is_sell;
        state_next   = state_reg;
        ord_next     = ord_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    ord_next = s_data;
                    if (s_data.order_qty != 16'd0) begin
                        state_next = ST_WORK;
                    end
                end
            end
            ST_WORK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next.aggressor_id = ord_reg.order_id;
                    if (crosses) begin
                        // Emit a trade at the resting price; advance or trim head.
                        m_data_next.kind       = KIND_TRADE;
                        m_data_next.resting_id = opp_head.id;
                        m_data_next.fill_price = opp_head.price;
                        m_data_next.fill_qty   = fill;
                        m_data_next.last       = (fill == ord_reg.order_qty);
                        ord_next.order_qty     = ord_reg.order_qty - fill;
                        if (fill == opp_head.qty) begin
                            opp_cmd.shift_up = 1'b1;
                        end else begin
                            opp_cmd.dec_head = 1'b1;
                            opp_cmd.dec_qty  = fill;
                        end
                        if (fill == ord_reg.order_qty) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        // Rest the remainder, or drop it when the table is full.
                        m_data_next.kind       = own_full ? KIND_DROPPED : KIND_RESTED;
                        m_data_next.resting_id = 16'd0;
                        m_data_next.fill_price = ord_reg.limit_price;
                        m_data_next.fill_qty   = ord_reg.order_qty;
                        m_data_next.last       = 1'b1;
                        own_cmd.insert         = !own_full;
                        state_next             = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        bid_cmd = ord_reg.is_sell ? opp_cmd : own_cmd;
        ask_cmd = ord_reg.is_sell ? own_cmd : opp_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        ord_reg    <= ord_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

/* hdl/lom_checker.sv */
// ----------------------------------------------------------------------------
// lom_checker
// Port-level checks of the matching core, bound to the top level.
// ----------------------------------------------------------------------------
`include "limit_order_matching_core_macros.svh"
module lom_checker
    import lom_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input order_t  s_data,
    input logic    m_valid,
    input logic    m_ready,
    input result_t m_data
);
    `LOM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `LOM_ASSERT_SAME(a_kind_ok, aclk, aresetn, m_valid, m_data.kind != 2'd3)
    `LOM_ASSERT_SAME(a_rem_last, aclk, aresetn, m_valid && m_data.kind != KIND_TRADE, m_data.last && m_data.resting_id == 16'd0)
    `LOM_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready && s_data.order_qty != 16'd0, !s_ready)
endmodule

bind limit_order_matching_core lom_checker u_lom_checker (.*);
